/* sv/projective_point_mapper_core_defines.svh */
// ----------------------------------------------------------------------------
// Projective point mapper assertion macros
// Shared assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PROJECTIVE_POINT_MAPPER_CORE_DEFINES_SVH
`define PROJECTIVE_POINT_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTH
// Checked only while the block is out of reset.
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PPM_ASSERT(lbl, clk, rst_n, prop, msg)
`define PPM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/ppm_pkg.sv */
// ----------------------------------------------------------------------------
// Projective point mapper package
// Widths, pipeline depths, status bit positions and shared types.
// ----------------------------------------------------------------------------
package ppm_pkg;

    localparam int OUT_WIDTH   = 16;
    localparam int COORD_W     = 32;
    localparam int COEF_W      = 32;
    localparam int PROD_W      = COORD_W + COEF_W;
    localparam int SUM_W       = PROD_W + 2;
    localparam int MAG_W       = 64;
    localparam int REM_W       = MAG_W + OUT_WIDTH;
    localparam int CFG_REGS    = 6;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 2 * COEF_W;
    localparam int ROW_STAGES  = 4;
    localparam int DIV_STAGES  = OUT_WIDTH + 2;
    localparam int PIPE_DEPTH  = ROW_STAGES + DIV_STAGES;
    localparam int IN_TDATA_W  = 3 * COORD_W;
    localparam int OUT_TDATA_W = ((2 * OUT_WIDTH + 7) / 8) * 8;
    localparam int TUSER_W     = 2;

    // Bit positions of the status flags in the output tuser.
    localparam int TUSER_ZERO_DEN = 0;
    localparam int TUSER_CLIPPED  = 1;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_row_sum;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] pixel;
        logic                 clipped;
        logic                 zero_den;
    } t_div_res;

endpackage

/* sv/ppm_row.sv */
// ----------------------------------------------------------------------------
// Projective point mapper row unit
// One matrix row: three products, constant term, exact sum, sign/magnitude.
// ----------------------------------------------------------------------------
module ppm_row import ppm_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [COORD_W-1:0] i_x,
    input  logic signed [COORD_W-1:0] i_y,
    input  logic signed [COORD_W-1:0] i_z,
    input  logic signed [COEF_W-1:0]  i_c0,
    input  logic signed [COEF_W-1:0]  i_c1,
    input  logic signed [COEF_W-1:0]  i_c2,
    input  logic signed [COEF_W-1:0]  i_c3,
    output t_row_sum                  o_sum
);

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic signed [COEF_W-1:0] r_c;
    logic [PROD_W:0]          r_s01, r_s2c;
    logic [SUM_W-1:0]         r_sum;
    t_row_sum                 r_out;
    logic [SUM_W-1:0]         n_abs;

    // The constant term is aligned to the product scale by a 16-bit shift.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= i_x * i_c0;
            r_p1  <= i_y * i_c1;
            r_p2  <= i_z * i_c2;
            r_c   <= i_c3;
            r_s01 <= {r_p0[PROD_W-1], r_p0} + {r_p1[PROD_W-1], r_p1};
            r_s2c <= {r_p2[PROD_W-1], r_p2} +
                     {{(PROD_W - COEF_W - 15){r_c[COEF_W-1]}}, r_c, 16'b0};
            r_sum <= {r_s01[PROD_W], r_s01} + {r_s2c[PROD_W], r_s2c};
            r_out <= '{neg: r_sum[SUM_W-1], mag: n_abs[MAG_W-1:0]};
        end
    end

    assign n_abs = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
    assign o_sum = r_out;

endmodule

/* sv/ppm_div.sv */
// ----------------------------------------------------------------------------
// Projective point mapper divider
// Pipelined restoring division, one quotient bit per stage, then rounding
// half away from zero and saturation.
// ----------------------------------------------------------------------------
module ppm_div import ppm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_en,
    input  t_row_sum i_num,
    input  t_row_sum i_den,
    output t_div_res o_res
);

    localparam logic [OUT_WIDTH:0] MAX_POS = (OUT_WIDTH+1)'((1 << (OUT_WIDTH - 1)) - 1);
    localparam logic [OUT_WIDTH:0] MAX_NEG = (OUT_WIDTH+1)'(1 << (OUT_WIDTH - 1));

    logic [REM_W-1:0]     r_rem  [0:OUT_WIDTH];
    logic [OUT_WIDTH-1:0] r_q    [0:OUT_WIDTH];
    logic [MAG_W-1:0]     r_dd   [0:OUT_WIDTH];
    logic                 r_neg  [0:OUT_WIDTH];
    logic                 r_zero [0:OUT_WIDTH];
    logic                 r_ovf  [0:OUT_WIDTH];
    t_div_res             r_res;

    // A quotient that needs more than OUT_WIDTH bits always saturates.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= REM_W'(i_num.mag);
            r_q[0]    <= '0;
            r_dd[0]   <= i_den.mag;
            r_neg[0]  <= i_num.neg ^ i_den.neg;
            r_zero[0] <= (i_den.mag == '0);
            r_ovf[0]  <= (i_num.mag >> OUT_WIDTH) >= i_den.mag;
        end
    end

    for (genvar k = 0; k < OUT_WIDTH; k++) begin : g_step
        localparam int SH = OUT_WIDTH - 1 - k;
        logic [REM_W:0]       trial;
        logic [OUT_WIDTH-1:0] n_q;

        always_comb begin
            trial    = {1'b0, r_rem[k]} - ((REM_W+1)'(r_dd[k]) << SH);
            n_q      = r_q[k];
            n_q[SH]  = ~trial[REM_W];
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= trial[REM_W] ? r_rem[k] : trial[REM_W-1:0];
                r_q[k+1]    <= n_q;
                r_dd[k+1]   <= r_dd[k];
                r_neg[k+1]  <= r_neg[k];
                r_zero[k+1] <= r_zero[k];
                r_ovf[k+1]  <= r_ovf[k];
            end
        end
    end

    logic               round_up;
    logic [OUT_WIDTH:0] q_rnd;
    t_div_res           n_res;

    always_comb begin
        round_up = {r_rem[OUT_WIDTH][MAG_W-1:0], 1'b0} >= {1'b0, r_dd[OUT_WIDTH]};
        q_rnd    = {1'b0, r_q[OUT_WIDTH]} + (OUT_WIDTH+1)'(round_up);
        n_res    = '{pixel: '0, clipped: 1'b0, zero_den: 1'b0};
        if (r_zero[OUT_WIDTH]) begin
            n_res.zero_den = 1'b1;
        end else if (!r_neg[OUT_WIDTH]) begin
            if (r_ovf[OUT_WIDTH] || q_rnd > MAX_POS) begin
                n_res.pixel   = MAX_POS[OUT_WIDTH-1:0];
                n_res.clipped = 1'b1;
            end else begin
                n_res.pixel = q_rnd[OUT_WIDTH-1:0];
            end
        end else begin
            if (r_ovf[OUT_WIDTH] || q_rnd > MAX_NEG) begin
                n_res.pixel   = MAX_NEG[OUT_WIDTH-1:0];
                n_res.clipped = 1'b1;
            end else begin
                n_res.pixel = OUT_WIDTH'(~q_rnd + (OUT_WIDTH+1)'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

/* sv/projective_point_mapper_core.sv */
// ----------------------------------------------------------------------------
// Projective point mapper core
// Maps a Q16.16 world point through a 3x4 Q2.30 projection matrix to a
// rounded, saturated projector pixel.
// ----------------------------------------------------------------------------
//
//  Channel   Ports              Transfer carries
//  --------  -----------------  -------------------------------------------
//  s (in)    i_s_*/o_s_tready   point_x, point_y, point_z
//  m (out)   o_m_*/i_m_tready   pixel_u, pixel_v; tuser zero_denominator,
//                               clipped
//  cfg       i_cfg_*/o_cfg_*    coefficient pair index and 64-bit value
//
//  One point enters per cycle while the output is not stalled. Each point
//  passes the row products and sums, then the divider's setup register,
//  its quotient bit stages and its rounding register. When the output
//  register holds a result that is not taken, the whole pipeline holds;
//  nothing is dropped or repeated. Synchronous active-low reset clears the
//  valid bits and the coefficient registers.
//
`include "projective_point_mapper_core_defines.svh"

module projective_point_mapper_core import ppm_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // tdata: point_x [31:0], point_y [63:32], point_z [95:64]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // tdata: pixel_u [OUT_WIDTH-1:0], pixel_v above it, zero padding on top
    output logic [OUT_TDATA_W-1:0] o_m_tdata,
    // tuser: zero_denominator [0], clipped [1]
    output logic [TUSER_W-1:0]     o_m_tuser,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [CFG_DATA_W-1:0] r_coef [0:CFG_REGS-1];
    logic [PIPE_DEPTH-1:0] r_valid;
    logic                  pipe_en;

    // Configuration writes are always taken; indexes past the last pair
    // are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_REGS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_valid && (int'(i_cfg_addr) < CFG_REGS)) begin
            r_coef[i_cfg_addr] <= i_cfg_data;
        end
    end

    // The pipeline advances whenever the output register is free or being
    // drained, so a new point can enter in the same cycle a result leaves.
    assign pipe_en    = !r_valid[PIPE_DEPTH-1] || i_m_tready;
    assign o_s_tready = pipe_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (pipe_en) begin
            r_valid <= {r_valid[PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    t_row_sum sum_x, sum_y, sum_d;

    // Row r uses pairs 2r (first two coefficients) and 2r+1 (third and
    // constant term).
    ppm_row u_row_x (
        .i_clk (i_clk), .i_en (pipe_en),
        .i_x   ($signed(i_s_tdata[31:0])),
        .i_y   ($signed(i_s_tdata[63:32])),
        .i_z   ($signed(i_s_tdata[95:64])),
        .i_c0  ($signed(r_coef[0][31:0])), .i_c1 ($signed(r_coef[0][63:32])),
        .i_c2  ($signed(r_coef[1][31:0])), .i_c3 ($signed(r_coef[1][63:32])),
        .o_sum (sum_x)
    );

    ppm_row u_row_y (
        .i_clk (i_clk), .i_en (pipe_en),
        .i_x   ($signed(i_s_tdata[31:0])),
        .i_y   ($signed(i_s_tdata[63:32])),
        .i_z   ($signed(i_s_tdata[95:64])),
        .i_c0  ($signed(r_coef[2][31:0])), .i_c1 ($signed(r_coef[2][63:32])),
        .i_c2  ($signed(r_coef[3][31:0])), .i_c3 ($signed(r_coef[3][63:32])),
        .o_sum (sum_y)
    );

    ppm_row u_row_d (
        .i_clk (i_clk), .i_en (pipe_en),
        .i_x   ($signed(i_s_tdata[31:0])),
        .i_y   ($signed(i_s_tdata[63:32])),
        .i_z   ($signed(i_s_tdata[95:64])),
        .i_c0  ($signed(r_coef[4][31:0])), .i_c1 ($signed(r_coef[4][63:32])),
        .i_c2  ($signed(r_coef[5][31:0])), .i_c3 ($signed(r_coef[5][63:32])),
        .o_sum (sum_d)
    );

    t_div_res res_u, res_v;

    // Both dividers share the denominator; each runs its own bit pipeline.
    ppm_div u_div_u (
        .i_clk (i_clk), .i_en (pipe_en),
        .i_num (sum_x), .i_den (sum_d),
        .o_res (res_u)
    );

    ppm_div u_div_v (
        .i_clk (i_clk), .i_en (pipe_en),
        .i_num (sum_y), .i_den (sum_d),
        .o_res (res_v)
    );

    assign o_m_tvalid = r_valid[PIPE_DEPTH-1];
    assign o_m_tdata  = OUT_TDATA_W'({res_v.pixel, res_u.pixel});

    always_comb begin
        o_m_tuser                 = '0;
        o_m_tuser[TUSER_ZERO_DEN] = res_u.zero_den;
        o_m_tuser[TUSER_CLIPPED]  = res_u.clipped | res_v.clipped;
    end

    // A point taken in must occupy the first pipeline slot in the next cycle.
    `PPM_ASSERT(a_enter, i_clk, i_rst_n, (i_s_tvalid && o_s_tready) |=> r_valid[0], "accepted point lost at pipeline entry")
    // A zero denominator forces both pixels to zero and no clipping.
    `PPM_ASSERT(a_zero_den, i_clk, i_rst_n, (o_m_tvalid && o_m_tuser[TUSER_ZERO_DEN]) |-> (o_m_tdata == '0 && !o_m_tuser[TUSER_CLIPPED]), "zero denominator result not cleared")
    // Both dividers must agree on the zero-denominator condition.
    `PPM_ASSERT(a_den_agree, i_clk, i_rst_n, o_m_tvalid |-> (res_u.zero_den == res_v.zero_den), "dividers disagree on zero denominator")
    // Reset empties the pipeline.
    `PPM_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> (!o_m_tvalid && r_valid == '0), "pipeline not empty after reset")

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// Projective point mapper core testbench
// Drives points through the 3x4 projection with random stalls on both
// streams, predicts each pixel with exact wide arithmetic and compares every
// output transfer field by field. Coefficients change only while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ppm_pkg::*;

    localparam int LIMIT = 2_000_000;

    typedef struct {
        logic [OUT_WIDTH-1:0] u;
        logic [OUT_WIDTH-1:0] v;
        logic                 zero_den;
        logic                 clipped;
    } t_pixel;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [TUSER_W-1:0]     o_m_tuser;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    projective_point_mapper_core DUT (.*);

    // Shadow of the coefficient registers, as the block sees them.
    logic [CFG_DATA_W-1:0] coef_regs [CFG_REGS];
    t_pixel                pending_pixels [$];
    int                    error_count = 0;
    int                    pixels_seen = 0;
    int                    points_sent = 0;
    int                    clip_seen = 0;
    int                    zero_seen = 0;
    longint                cycle_count = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: the run must end well inside this many cycles.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("** projective_point_mapper_core: FAILED **");
            $finish;
        end
    end

    function automatic logic signed [31:0] coef(int k);
        logic [63:0] pair;
        pair = coef_regs[k / 2];
        return (k % 2) ? pair[63:32] : pair[31:0];
    endfunction

    // Exact row sum in Q18.46; 80 bits leave ample headroom.
    function automatic logic signed [79:0] row_value(int row, logic signed [31:0] p [3]);
        logic signed [79:0] acc;
        acc = 80'(coef(row * 4 + 3)) <<< 16;
        for (int j = 0; j < 3; j++) acc += 80'(p[j]) * 80'(coef(row * 4 + j));
        return acc;
    endfunction

    // Quotient rounded half away from zero, saturated to OUT_WIDTH bits.
    function automatic logic [OUT_WIDTH-1:0] rounded_pixel(logic signed [79:0] num,
                                                          logic signed [79:0] den,
                                                          ref logic clip);
        logic [79:0] n, d, q, r;
        logic        neg;
        logic [79:0] maxpos, maxneg;
        maxpos = (80'd1 << (OUT_WIDTH - 1)) - 1;
        maxneg = 80'd1 << (OUT_WIDTH - 1);
        n = num < 0 ? -num : num;
        d = den < 0 ? -den : den;
        neg = (num < 0) != (den < 0);
        q = n / d;
        r = n % d;
        if (r >= d - r) q++;
        if (q == 0) return '0;
        if (!neg) begin
            if (q > maxpos) begin
                clip = 1'b1;
                q = maxpos;
            end
            return q[OUT_WIDTH-1:0];
        end
        if (q > maxneg) begin
            clip = 1'b1;
            q = maxneg;
        end
        return OUT_WIDTH'(-q);
    endfunction

    function automatic t_pixel project_point(logic [IN_TDATA_W-1:0] pt);
        logic signed [31:0] p [3];
        logic signed [79:0] nx, ny, d;
        t_pixel             px;
        logic               clip;
        for (int j = 0; j < 3; j++) p[j] = pt[j*32 +: 32];
        nx = row_value(0, p);
        ny = row_value(1, p);
        d = row_value(2, p);
        clip = 1'b0;
        px = '{default: '0};
        if (d == 0) begin
            px.zero_den = 1'b1;
            return px;
        end
        px.u = rounded_pixel(nx, d, clip);
        px.v = rounded_pixel(ny, d, clip);
        px.clipped = clip;
        return px;
    endfunction

    // Result checker with a random receiver stall before each transfer.
    // Ready stays up after a transfer unless an idle gap takes it down.
    initial begin
        int     gap;
        t_pixel exp_px;
        @(posedge i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            pixels_seen++;
            if (pending_pixels.size() == 0) begin
                $error("output transfer with no pending pixel");
                error_count++;
            end else begin
                exp_px = pending_pixels.pop_front();
                if (o_m_tdata[OUT_WIDTH-1:0] !== exp_px.u) begin
                    $error("pixel_u exp %0d got %0d", $signed(exp_px.u),
                           $signed(o_m_tdata[OUT_WIDTH-1:0]));
                    error_count++;
                end
                if (o_m_tdata[2*OUT_WIDTH-1:OUT_WIDTH] !== exp_px.v) begin
                    $error("pixel_v exp %0d got %0d", $signed(exp_px.v),
                           $signed(o_m_tdata[2*OUT_WIDTH-1:OUT_WIDTH]));
                    error_count++;
                end
                if (o_m_tuser[TUSER_ZERO_DEN] !== exp_px.zero_den) begin
                    $error("zero_denominator exp %0b got %0b", exp_px.zero_den,
                           o_m_tuser[TUSER_ZERO_DEN]);
                    error_count++;
                end
                if (o_m_tuser[TUSER_CLIPPED] !== exp_px.clipped) begin
                    $error("clipped exp %0b got %0b", exp_px.clipped,
                           o_m_tuser[TUSER_CLIPPED]);
                    error_count++;
                end
                clip_seen += exp_px.clipped;
                zero_seen += exp_px.zero_den;
            end
        end
    end

    // Valid stays up after a transfer until the next point replaces the data
    // or an idle gap (or the drain wait) takes it down.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tdata <= {z, y, x};
        i_s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        pending_pixels.insert(pending_pixels.size(), project_point({z, y, x}));
        points_sent++;
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    // Writes one register; an index past the last pair is dropped by the block.
    task automatic write_coef(int idx, logic [63:0] value);
        i_cfg_addr <= CFG_ADDR_W'(idx);
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        if (idx < CFG_REGS) coef_regs[idx] = value;
    endtask

    // Matrix given as twelve Q2.30 values, row major.
    task automatic load_matrix(logic [31:0] m [12]);
        for (int i = 0; i < CFG_REGS; i++) write_coef(i, {m[2*i+1], m[2*i]});
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3: return 32'($signed($urandom_range(0, 20)) - 10) <<< 16;
            default: return $urandom;
        endcase
    endfunction

    // Zero matrix after reset: every point has a zero denominator.
    task automatic test_reset_matrix();
        send_point('0, '0, '0);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678);
        wait_drained();
    endtask

    // Identity-like camera: u = x/z, v = y/z, covering rounding, clipping
    // both ways, a zero numerator and a zero depth.
    task automatic test_directed();
        logic [31:0] m [12];
        m = '{32'h4000_0000, 0, 0, 0,  0, 32'h4000_0000, 0, 0,
              0, 0, 32'h4000_0000, 0};
        load_matrix(m);
        write_coef(7, '1);
        send_point(32'h0001_8000, 32'hFFFE_8000, 32'h0001_0000); // halves
        send_point(32'h0002_8000, 32'hFFFD_8000, 32'h0002_0000);
        send_point(32'h0000_0000, 32'h0000_0001, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001); // saturate
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h1234_0000, 32'h0567_0000, 32'h0000_0000); // zero depth
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
        wait_drained();
        // Extreme coefficients on every term.
        foreach (m[i]) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        load_matrix(m);
        for (int i = 0; i < 8; i++) send_point(rand_word(), rand_word(), rand_word());
        wait_drained();
    endtask

    // Random matrices with random points; sets of moderate scale keep most
    // pixels in range while a few are deliberately wild.
    task automatic test_random();
        logic [31:0] m [12];
        for (int set = 0; set < 14; set++) begin
            foreach (m[i]) begin
                if (set % 4 == 3) m[i] = $urandom;
                else m[i] = 32'($signed($urandom_range(0, 2000)) - 1000) <<< 20;
            end
            if (set % 2 == 0) m[10] = 32'h4000_0000 + ($urandom & 32'h00FF_FFFF);
            load_matrix(m);
            for (int k = 0; k < 50; k++) begin
                if ($urandom_range(0, 2) == 0)
                    send_point(rand_word(), rand_word(), rand_word());
                else
                    send_point(32'($signed($urandom_range(0, 1000)) - 500) <<< 12,
                               32'($signed($urandom_range(0, 1000)) - 500) <<< 12,
                               32'($urandom_range(1, 4000)) <<< 12);
            end
            // The sender holds off until everything in flight has come back.
            wait_drained();
        end
    endtask

    initial begin
        foreach (coef_regs[i]) coef_regs[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_matrix();
        test_directed();
        test_random();
        wait_drained();
        $display("Sent %0d points, checked %0d pixels (%0d clipped, %0d zero depth).",
                 points_sent, pixels_seen, clip_seen, zero_seen);
        $display("Coefficient sets included all-zero, identity and extreme values.");
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("** projective_point_mapper_core: PASSED **");
        end else begin
            $display("** projective_point_mapper_core: FAILED **");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+sv
sv/ppm_pkg.sv
sv/ppm_row.sv
sv/ppm_div.sv
sv/projective_point_mapper_core.sv
dv/tb.sv
